/* hdl/stsl_pkg.sv */
// ----------------------------------------------------------------------------
// stsl_pkg: shared types and constants of the timestep schedule list
// Operation codes, the timestep width and the controller state encoding.
// ----------------------------------------------------------------------------
`default_nettype none

package stsl_pkg;

  localparam int TS_W = 63;
  localparam int HELD_W = 5;

  localparam logic [1:0] FUNC_ADD   = 2'd0;
  localparam logic [1:0] FUNC_MATCH = 2'd1;
  localparam logic [1:0] FUNC_CLEAR = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SCAN  = 4'b0010,
    ST_SHIFT = 4'b0100,
    ST_INS   = 4'b1000
  } state_t;

endpackage

`default_nettype wire

/* hdl/stsl_ram.sv */
// ----------------------------------------------------------------------------
// stsl_ram: generic single-port-write, single-port-read RAM
// One write and one read per cycle; the read data is registered.
// ----------------------------------------------------------------------------
`default_nettype none

module stsl_ram #(
  parameter int WIDTH = 63,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* hdl/sorted_timestep_schedule_list.sv */
// ----------------------------------------------------------------------------
// sorted_timestep_schedule_list: sorted, duplicate-free list of timesteps
// Entries sit in a RAM in decreasing order, the smallest in the highest
// used slot. A sequencer scans from the top, pops, shifts and inserts.
//
//   channel   signals                       handshake
//   command   start, func, timestep         taken when start && !busy
//   result    done, matched, dropped,       done high for one cycle
//             entries_held
//
// A clear or an unused code completes straight from idle. A match reads
// entries from the top, popping smaller ones. An add scans from the top,
// moves the entries above its slot up one by one, then writes the new one.
// The RAM's single read port paces the scan and the shift.
// The result strobe is registered and follows in the cycle after the last
// step. Reset clears the entry count, the state and the result flags; no
// clearing pass runs. Results cannot be stalled.
`default_nettype none

module sorted_timestep_schedule_list #(
  parameter int DEPTH = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [1:0]                    func,
  input  wire logic [stsl_pkg::TS_W-1:0]     timestep,
  output logic                               done,
  output logic                               matched,
  output logic                               dropped,
  output logic      [stsl_pkg::HELD_W-1:0]   entries_held
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  stsl_pkg::state_t state, state_next;
  logic [CW-1:0]    cnt, cnt_next;
  logic [stsl_pkg::TS_W-1:0] ts_r, ts_r_next;
  logic             is_add, is_add_next;
  logic [AW-1:0]    ptr, ptr_next;
  logic [CW-1:0]    pos, pos_next;
  logic [CW-1:0]    wptr, wptr_next;
  logic             done_next, matched_next, dropped_next;

  logic                      we;
  logic [AW-1:0]             waddr, raddr;
  logic [stsl_pkg::TS_W-1:0] wdata, rdata;

  logic [CW-1:0] cnt_m1, wptr_m1, wptr_m2, p_val;
  logic          go_ins, ts_lt, ts_eq;
  logic [CW+stsl_pkg::HELD_W-1:0] cnt_ext;

  stsl_ram #(
    .WIDTH(stsl_pkg::TS_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  assign cnt_m1  = CW'(cnt - 1'b1);
  assign wptr_m1 = CW'(wptr - 1'b1);
  assign wptr_m2 = CW'(wptr - 2'd2);
  assign ts_lt   = ts_r < rdata;
  assign ts_eq   = ts_r == rdata;

  always_comb begin
    state_next   = state;
    cnt_next     = cnt;
    ts_r_next    = ts_r;
    is_add_next  = is_add;
    ptr_next     = ptr;
    pos_next     = pos;
    wptr_next    = wptr;
    done_next    = 1'b0;
    matched_next = 1'b0;
    dropped_next = 1'b0;
    we           = 1'b0;
    waddr        = pos[AW-1:0];
    wdata        = ts_r;
    raddr        = AW'(ptr - 1'b1);
    go_ins       = 1'b0;
    p_val        = '0;

    unique case (state)
      stsl_pkg::ST_IDLE: begin
        if (start) begin
          ts_r_next   = timestep;
          is_add_next = (func == stsl_pkg::FUNC_ADD);
          unique case (func)
            stsl_pkg::FUNC_ADD, stsl_pkg::FUNC_MATCH: begin
              if (cnt == '0) begin
                if (func == stsl_pkg::FUNC_ADD) begin
                  pos_next   = '0;
                  state_next = stsl_pkg::ST_INS;
                end else begin
                  done_next = 1'b1;
                end
              end else begin
                raddr      = cnt_m1[AW-1:0];
                ptr_next   = cnt_m1[AW-1:0];
                state_next = stsl_pkg::ST_SCAN;
              end
            end
            stsl_pkg::FUNC_CLEAR: begin
              cnt_next  = '0;
              done_next = 1'b1;
            end
            default: begin
              done_next = 1'b1;
            end
          endcase
        end
      end

      stsl_pkg::ST_SCAN: begin
        // The read of the next lower slot is issued every cycle ahead of need.
        if (is_add) begin
          if (ts_eq) begin
            done_next  = 1'b1;
            state_next = stsl_pkg::ST_IDLE;
          end else if (ts_lt) begin
            go_ins = 1'b1;
            p_val  = CW'(CW'(ptr) + 1'b1);
          end else if (ptr == '0) begin
            go_ins = 1'b1;
            p_val  = '0;
          end else begin
            ptr_next = AW'(ptr - 1'b1);
          end
        end else begin
          if (ts_lt || ts_eq) begin
            matched_next = ts_eq;
            done_next    = 1'b1;
            state_next   = stsl_pkg::ST_IDLE;
          end else begin
            // Smaller entry on top: pop it.
            cnt_next = CW'(ptr);
            if (ptr == '0) begin
              done_next  = 1'b1;
              state_next = stsl_pkg::ST_IDLE;
            end else begin
              ptr_next = AW'(ptr - 1'b1);
            end
          end
        end
      end

      stsl_pkg::ST_SHIFT: begin
        we    = 1'b1;
        waddr = wptr[AW-1:0];
        wdata = rdata;
        if (wptr_m1 == pos) begin
          state_next = stsl_pkg::ST_INS;
        end else begin
          wptr_next = wptr_m1;
          raddr     = wptr_m2[AW-1:0];
        end
      end

      stsl_pkg::ST_INS: begin
        we         = 1'b1;
        waddr      = pos[AW-1:0];
        wdata      = ts_r;
        cnt_next   = CW'(cnt + 1'b1);
        done_next  = 1'b1;
        state_next = stsl_pkg::ST_IDLE;
      end

      default: begin
        state_next = stsl_pkg::ST_IDLE;
      end
    endcase

    // Slot found for an add: drop on a full list, else move entries up where needed and insert.
    if (go_ins) begin
      pos_next = p_val;
      if (cnt == CW'(DEPTH)) begin
        dropped_next = 1'b1;
        done_next    = 1'b1;
        state_next   = stsl_pkg::ST_IDLE;
      end else if (cnt == p_val) begin
        state_next = stsl_pkg::ST_INS;
      end else begin
        raddr      = cnt_m1[AW-1:0];
        wptr_next  = cnt;
        state_next = stsl_pkg::ST_SHIFT;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= stsl_pkg::ST_IDLE;
      cnt     <= '0;
      done    <= 1'b0;
      matched <= 1'b0;
      dropped <= 1'b0;
    end else begin
      state   <= state_next;
      cnt     <= cnt_next;
      done    <= done_next;
      matched <= matched_next;
      dropped <= dropped_next;
    end
    ts_r   <= ts_r_next;
    is_add <= is_add_next;
    ptr    <= ptr_next;
    pos    <= pos_next;
    wptr   <= wptr_next;
  end

  assign busy         = (state != stsl_pkg::ST_IDLE);
  assign cnt_ext      = {{stsl_pkg::HELD_W{1'b0}}, cnt};
  assign entries_held = cnt_ext[stsl_pkg::HELD_W-1:0];

endmodule

`default_nettype wire
